// ===== hdl/pwlm_pkg.sv =====
// Shared types, constants and codes for the periodic wakeup latency monitor.
`timescale 1ns / 1ps
`default_nettype none

package pwlm_pkg;

    // Field widths
    localparam int NOW_W       = 63;
    localparam int LAT_W       = 64;
    localparam int IV_W        = 30;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Remainder unit: one dividend bit per cycle
    localparam int DIV_STEPS   = NOW_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Constants
    localparam logic [NOW_W-1:0] NS_PER_SEC        = 63'd1000000000;
    localparam logic [IV_W-1:0]  RESET_INTERVAL_NS = 30'd100000;
    localparam logic [NOW_W-1:0] RESET_RUN_NS      = 63'd1000000000;
    localparam logic [NOW_W-1:0] SUM_MAX           = {NOW_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_MAX         = {CNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL   = 2'd0,
        CFG_RUN_LENGTH = 2'd1
    } t_cfg_idx;

    // Item classes
    typedef enum logic {
        OP_START = 1'b0,
        OP_WAKE  = 1'b1
    } t_op;

    // Engine states
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_LAT  = 3'd1,
        ST_EVAL = 3'd2,
        ST_DIV  = 3'd3,
        ST_FIX  = 3'd4
    } t_state;

    typedef struct packed {
        logic             func;
        logic [NOW_W-1:0] now_ns;
    } t_in_item;

    typedef struct packed {
        logic signed [LAT_W-1:0] latency_ns;
        logic                    counted;
        logic [NOW_W-1:0]        min_latency_ns;
        logic [NOW_W-1:0]        max_latency_ns;
        logic [NOW_W-1:0]        latency_sum_ns;
        logic [CNT_W-1:0]        sample_count;
        logic                    finished;
    } t_out_item;

    // Classified item held in the queue between front and back
    typedef struct packed {
        t_op              op;
        logic [NOW_W-1:0] now_ns;
    } t_q_item;

    typedef struct packed {
        logic [IV_W-1:0]  interval_ns;
        logic [NOW_W-1:0] run_length_ns;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/pwlm_front.sv =====
// Front end: accepts input items, classifies them, and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none

module pwlm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  pwlm_pkg::t_in_item  i_data,
    output logic                o_q_valid,
    output pwlm_pkg::t_q_item   o_q_item,
    input  wire                 i_q_pop
);

    // Two-entry queue
    pwlm_pkg::t_q_item r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic              push;
    pwlm_pkg::t_q_item cls_item;

    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rptr];

    // Classify the function code
    always_comb begin
        cls_item.op     = i_data.func ? pwlm_pkg::OP_WAKE : pwlm_pkg::OP_START;
        cls_item.now_ns = i_data.now_ns;
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cls_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/pwlm_back.sv =====
// Back end: latency, statistics, deadline catch-up and the result register.
`timescale 1ns / 1ps
`default_nettype none

module pwlm_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pwlm_pkg::t_cfg      i_cfg,
    input  wire                 i_q_valid,
    input  pwlm_pkg::t_q_item   i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output pwlm_pkg::t_out_item o_data
);

    pwlm_pkg::t_state r_state;
    pwlm_pkg::t_state n_state;

    // Current item
    pwlm_pkg::t_op                  r_op;
    logic [pwlm_pkg::NOW_W-1:0]     r_now;

    // Measurement state
    logic [pwlm_pkg::LAT_W-1:0]     r_deadline;
    logic [pwlm_pkg::LAT_W-1:0]     r_stop;
    logic [pwlm_pkg::NOW_W-1:0]     r_lowest;
    logic [pwlm_pkg::NOW_W-1:0]     r_highest;
    logic [pwlm_pkg::NOW_W-1:0]     r_total;
    logic [pwlm_pkg::CNT_W-1:0]     r_samples;
    logic                           r_done;

    // Latency stage
    logic [pwlm_pkg::LAT_W-1:0]     r_lat;
    logic                           r_ge;
    logic                           r_gt;
    logic                           r_fin;

    // Remainder unit
    logic [pwlm_pkg::IV_W-1:0]      r_rem;
    logic [pwlm_pkg::NOW_W-1:0]     r_dvd;
    logic [pwlm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [pwlm_pkg::IV_W:0]        rem_sh;
    logic [pwlm_pkg::IV_W:0]        rem_diff;

    // Result slot and output register
    pwlm_pkg::t_out_item            r_res;
    logic                           r_pend;
    pwlm_pkg::t_out_item            r_out;
    logic                           r_out_valid;
    logic                           move;

    // Control
    logic                           div_last;
    logic                           catchup_go;
    logic [pwlm_pkg::IV_W-1:0]      iv_eff;
    logic [pwlm_pkg::LAT_W-1:0]     now_ext;

    // Next statistics for a live wakeup
    logic [pwlm_pkg::NOW_W-1:0]     n_lowest;
    logic [pwlm_pkg::NOW_W-1:0]     n_highest;
    logic [pwlm_pkg::NOW_W-1:0]     n_total;
    logic [pwlm_pkg::CNT_W-1:0]     n_samples;
    logic [pwlm_pkg::LAT_W-1:0]     sum_ext;

    assign iv_eff   = (i_cfg.interval_ns == '0) ? pwlm_pkg::IV_W'(1) : i_cfg.interval_ns;
    assign now_ext  = {1'b0, r_now};
    assign div_last = (r_cnt == pwlm_pkg::DIV_CNT_W'(pwlm_pkg::DIV_STEPS - 1));
    assign catchup_go = (r_op == pwlm_pkg::OP_WAKE) && !r_done && !r_fin && r_gt;
    assign move     = r_pend && (!r_out_valid || i_ready);

    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pwlm_pkg::ST_IDLE: begin
                if (i_q_valid && !r_pend) begin
                    n_state = pwlm_pkg::ST_LAT;
                end
            end
            pwlm_pkg::ST_LAT: begin
                n_state = pwlm_pkg::ST_EVAL;
            end
            pwlm_pkg::ST_EVAL: begin
                n_state = catchup_go ? pwlm_pkg::ST_DIV : pwlm_pkg::ST_IDLE;
            end
            pwlm_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = pwlm_pkg::ST_FIX;
                end
            end
            pwlm_pkg::ST_FIX: begin
                n_state = pwlm_pkg::ST_IDLE;
            end
            default: begin
                n_state = pwlm_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop = 1'b0;
        case (r_state)
            pwlm_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid && !r_pend;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwlm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Statistics update for a wakeup that is still measuring
    always_comb begin
        sum_ext   = {1'b0, r_total} + {1'b0, r_lat[pwlm_pkg::NOW_W-1:0]};
        n_lowest  = r_lowest;
        n_highest = r_highest;
        n_total   = r_total;
        n_samples = r_samples;
        if (r_ge) begin
            if (r_lat[pwlm_pkg::NOW_W-1:0] < r_lowest) begin
                n_lowest = r_lat[pwlm_pkg::NOW_W-1:0];
            end
            if (r_lat[pwlm_pkg::NOW_W-1:0] > r_highest) begin
                n_highest = r_lat[pwlm_pkg::NOW_W-1:0];
            end
            n_total = sum_ext[pwlm_pkg::LAT_W-1] ? pwlm_pkg::SUM_MAX
                                                 : sum_ext[pwlm_pkg::NOW_W-1:0];
            if (r_samples != pwlm_pkg::COUNT_MAX) begin
                n_samples = r_samples + pwlm_pkg::CNT_W'(1);
            end
        end
    end

    // Remainder step: shift in one dividend bit, subtract when it fits
    always_comb begin
        rem_sh   = {r_rem, r_dvd[pwlm_pkg::NOW_W-1]};
        rem_diff = rem_sh - {1'b0, iv_eff};
    end

    // Item capture, latency stage and remainder unit
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op  <= i_q_item.op;
            r_now <= i_q_item.now_ns;
        end
        if (r_state == pwlm_pkg::ST_LAT) begin
            r_lat <= now_ext - r_deadline;
            r_ge  <= now_ext >= r_deadline;
            r_gt  <= now_ext > r_deadline;
            r_fin <= now_ext >= r_stop;
        end
        if (r_state == pwlm_pkg::ST_EVAL) begin
            r_rem <= '0;
            r_dvd <= r_lat[pwlm_pkg::NOW_W-1:0] - pwlm_pkg::NOW_W'(1);
            r_cnt <= '0;
        end else if (r_state == pwlm_pkg::ST_DIV) begin
            r_rem <= (rem_sh >= {1'b0, iv_eff}) ? rem_diff[pwlm_pkg::IV_W-1:0]
                                                 : rem_sh[pwlm_pkg::IV_W-1:0];
            r_dvd <= {r_dvd[pwlm_pkg::NOW_W-2:0], 1'b0};
            r_cnt <= r_cnt + pwlm_pkg::DIV_CNT_W'(1);
        end
    end

    // Measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
            r_stop     <= '0;
            r_lowest   <= pwlm_pkg::NS_PER_SEC;
            r_highest  <= '0;
            r_total    <= '0;
            r_samples  <= '0;
            r_done     <= 1'b0;
        end else if (r_state == pwlm_pkg::ST_EVAL) begin
            if (r_op == pwlm_pkg::OP_START) begin
                r_stop     <= now_ext + {1'b0, i_cfg.run_length_ns};
                r_deadline <= now_ext + {{(pwlm_pkg::LAT_W - pwlm_pkg::IV_W){1'b0}},
                                         i_cfg.interval_ns};
                r_lowest   <= pwlm_pkg::NS_PER_SEC;
                r_highest  <= '0;
                r_total    <= '0;
                r_samples  <= '0;
                r_done     <= 1'b0;
            end else if (!r_done) begin
                r_lowest  <= n_lowest;
                r_highest <= n_highest;
                r_total   <= n_total;
                r_samples <= n_samples;
                if (r_fin) begin
                    r_done <= 1'b1;
                end else if (!r_gt) begin
                    r_deadline <= r_deadline + {{(pwlm_pkg::LAT_W - pwlm_pkg::IV_W){1'b0}},
                                                iv_eff};
                end
            end
        end else if (r_state == pwlm_pkg::ST_FIX) begin
            // Next deadline: now - 1 - ((now - deadline - 1) mod iv) + iv
            r_deadline <= now_ext - pwlm_pkg::LAT_W'(1)
                          - {{(pwlm_pkg::LAT_W - pwlm_pkg::IV_W){1'b0}}, r_rem}
                          + {{(pwlm_pkg::LAT_W - pwlm_pkg::IV_W){1'b0}}, iv_eff};
        end
    end

    // Result slot, filled when the item is evaluated
    always_ff @(posedge i_clk) begin
        if (r_state == pwlm_pkg::ST_EVAL) begin
            if (r_op == pwlm_pkg::OP_START) begin
                r_res.latency_ns     <= '0;
                r_res.counted        <= 1'b0;
                r_res.min_latency_ns <= pwlm_pkg::NS_PER_SEC;
                r_res.max_latency_ns <= '0;
                r_res.latency_sum_ns <= '0;
                r_res.sample_count   <= '0;
                r_res.finished       <= 1'b0;
            end else if (r_done) begin
                r_res.latency_ns     <= '0;
                r_res.counted        <= 1'b0;
                r_res.min_latency_ns <= r_lowest;
                r_res.max_latency_ns <= r_highest;
                r_res.latency_sum_ns <= r_total;
                r_res.sample_count   <= r_samples;
                r_res.finished       <= 1'b1;
            end else begin
                r_res.latency_ns     <= r_lat;
                r_res.counted        <= r_ge;
                r_res.min_latency_ns <= n_lowest;
                r_res.max_latency_ns <= n_highest;
                r_res.latency_sum_ns <= n_total;
                r_res.sample_count   <= n_samples;
                r_res.finished       <= r_fin;
            end
        end
        if (move) begin
            r_out <= r_res;
        end
    end

    // Result handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == pwlm_pkg::ST_EVAL) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pwlm_pkg::ST_EVAL |-> !r_pend)
        else $error("result slot overwritten");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwlm_pkg::ST_DIV && div_last) |=> r_state == pwlm_pkg::ST_FIX)
        else $error("remainder unit did not finish");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwlm_pkg::ST_EVAL && r_op == pwlm_pkg::OP_START)
        |=> (!r_done && r_samples == '0 && r_total == '0))
        else $error("start did not clear statistics");

    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lowest <= pwlm_pkg::NS_PER_SEC)
        else $error("minimum above initial value");

endmodule

`default_nettype wire

// ===== hdl/periodic_wakeup_latency_monitor_top.sv =====
// Top level: configuration registers, front end queue and measurement engine.
`timescale 1ns / 1ps
`default_nettype none

// Periodic wakeup latency monitor. A start item (func 0) arms a measurement
// window at now_ns; each wakeup item (func 1) returns now minus the expected
// deadline and the running min/max/sum/count, until the stop time is reached.
// Items are worked one at a time: a start, an ignored wakeup, or a wakeup
// at or before its deadline or at or past the stop time passes the latency
// and evaluate states; a late wakeup before the stop time then also runs
// the deadline catch-up, a bit-serial remainder unit over the 63-bit
// lateness, one bit per cycle, and a fix-up state. A two-entry queue takes
// items while the engine works, and a result slot plus output register let
// one result wait on the consumer without stalling the engine.
// Write interval_ns and run_length_ns only while no item is in flight.

module periodic_wakeup_latency_monitor_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  pwlm_pkg::t_in_item                 i_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output pwlm_pkg::t_out_item                o_data,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [pwlm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [pwlm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [pwlm_pkg::IV_W-1:0]  r_interval;
    logic [pwlm_pkg::NOW_W-1:0] r_run_length;
    pwlm_pkg::t_cfg             cfg;
    logic                       q_valid;
    logic                       q_pop;
    pwlm_pkg::t_q_item          q_item;

    assign o_cfg_ready     = 1'b1;
    assign cfg.interval_ns   = r_interval;
    assign cfg.run_length_ns = r_run_length;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= pwlm_pkg::RESET_INTERVAL_NS;
            r_run_length <= pwlm_pkg::RESET_RUN_NS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pwlm_pkg::CFG_INTERVAL: begin
                    r_interval <= i_cfg_data[pwlm_pkg::IV_W-1:0];
                end
                pwlm_pkg::CFG_RUN_LENGTH: begin
                    r_run_length <= i_cfg_data[pwlm_pkg::NOW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pwlm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    pwlm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

`default_nettype wire

// ===== test/tb_periodic_wakeup_latency_monitor_top.sv =====
// Self-checking testbench for the periodic wakeup latency monitor top level.
`timescale 1ns / 1ps

module tb_periodic_wakeup_latency_monitor_top;
    import pwlm_pkg::*;

    localparam int          RAND_ITEMS   = 1850;
    localparam int          WATCHDOG_MAX = 4000;
    localparam int          SETTLE_CYCLES = 16;
    localparam logic [63:0] MAX63        = {1'b0, SUM_MAX};
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    // Receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_COMB   = 2'd3
    } t_rx_mode;

    // One row of the directed stimulus
    typedef struct {
        bit          is_cfg;
        t_cfg_idx    cfg_idx;
        logic [63:0] cfg_data;
        t_in_item    item;
        bit          typed;
        t_out_item   want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    periodic_wakeup_latency_monitor_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the monitor's registers and measurement state
    logic [IV_W-1:0]  cfg_interval   = RESET_INTERVAL_NS;
    logic [NOW_W-1:0] cfg_run_length = RESET_RUN_NS;
    logic [63:0]      cur_deadline   = '0;
    logic [63:0]      cur_stop       = '0;
    logic [63:0]      cur_lowest     = {1'b0, NS_PER_SEC};
    logic [63:0]      cur_highest    = '0;
    logic [63:0]      cur_total      = '0;
    logic [CNT_W-1:0] cur_samples    = '0;
    logic             cur_done       = 1'b0;

    t_out_item   expected_stats_q[$];
    t_stim_row   stim_rows[$];
    int          errors      = 0;
    int          live_items  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    logic [31:0] cyc_cnt     = '0;
    t_rx_mode    rx_mode     = RX_OPEN;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_stats();
        cur_lowest  = {1'b0, NS_PER_SEC};
        cur_highest = '0;
        cur_total   = '0;
        cur_samples = '0;
        cur_done    = 1'b0;
    endfunction

    function automatic t_out_item make_stats(input logic [63:0] lat, input logic cnt_flag,
                                             input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [63:0] sum, input logic [31:0] cnt,
                                             input logic fin);
        t_out_item r;
        r.latency_ns     = lat;
        r.counted        = cnt_flag;
        r.min_latency_ns = lo[NOW_W-1:0];
        r.max_latency_ns = hi[NOW_W-1:0];
        r.latency_sum_ns = sum[NOW_W-1:0];
        r.sample_count   = cnt;
        r.finished       = fin;
        return r;
    endfunction

    // Predict one result and advance the shadow state
    function automatic t_out_item predict_wakeup_stats(input t_in_item item);
        logic [63:0] now;
        logic [63:0] lat;
        logic [63:0] iv;
        logic [63:0] steps;
        logic        cnt_flag;
        now      = {1'b0, item.now_ns};
        lat      = '0;
        cnt_flag = 1'b0;
        if (item.func == OP_START) begin
            cur_stop     = now + {1'b0, cfg_run_length};
            cur_deadline = now + {{(64-IV_W){1'b0}}, cfg_interval};
            clear_stats();
        end else if (!cur_done) begin
            iv  = (cfg_interval == '0) ? 64'd1 : {{(64-IV_W){1'b0}}, cfg_interval};
            lat = now - cur_deadline;
            if (now >= cur_deadline) begin
                cnt_flag = 1'b1;
                if (lat < cur_lowest)
                    cur_lowest = lat;
                if (lat > cur_highest)
                    cur_highest = lat;
                if (lat > MAX63 - cur_total)
                    cur_total = MAX63;
                else
                    cur_total = cur_total + lat;
                if (cur_samples != COUNT_MAX)
                    cur_samples = cur_samples + 1'b1;
            end
            if (now >= cur_stop) begin
                cur_done = 1'b1;
            end else begin
                // catch the deadline up by whole intervals, at least one
                steps = 64'd1;
                if (now > cur_deadline)
                    steps = (now - cur_deadline + iv - 64'd1) / iv;
                cur_deadline = cur_deadline + steps * iv;
            end
        end
        return make_stats(lat, cnt_flag, cur_lowest, cur_highest, cur_total,
                          cur_samples, cur_done);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic check_stats(input t_out_item got, input t_out_item want);
        if (got.latency_ns !== want.latency_ns)
            report_mismatch("latency_ns", got.latency_ns, want.latency_ns);
        if (got.counted !== want.counted)
            report_mismatch("counted", got.counted, want.counted);
        if (got.min_latency_ns !== want.min_latency_ns)
            report_mismatch("min_latency_ns", got.min_latency_ns, want.min_latency_ns);
        if (got.max_latency_ns !== want.max_latency_ns)
            report_mismatch("max_latency_ns", got.max_latency_ns, want.max_latency_ns);
        if (got.latency_sum_ns !== want.latency_sum_ns)
            report_mismatch("latency_sum_ns", got.latency_sum_ns, want.latency_sum_ns);
        if (got.sample_count !== want.sample_count)
            report_mismatch("sample_count", got.sample_count, want.sample_count);
        if (got.finished !== want.finished)
            report_mismatch("finished", got.finished, want.finished);
    endtask

    // Send one item in bursts; typed rows replace the predicted result
    task automatic drive_item(input t_in_item item, input bit typed, input t_out_item want);
        t_out_item pred;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        if (!(item.func == OP_WAKE && cur_done))
            live_items++;
        pred = predict_wakeup_stats(item);
        expected_stats_q.push_back(typed ? want : pred);
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_item(input t_op op, input logic [63:0] now);
        t_in_item item;
        item.func   = op;
        item.now_ns = now[NOW_W-1:0];
        drive_item(item, 1'b0, '0);
    endtask

    // Let every outstanding result drain before touching registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_stats_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_INTERVAL)
            cfg_interval = data[IV_W-1:0];
        else if (idx == CFG_RUN_LENGTH)
            cfg_run_length = data[NOW_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [63:0] data);
        t_stim_row r;
        r          = '{cfg_idx: CFG_INTERVAL, default: '0};
        r.is_cfg   = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        stim_rows.push_back(r);
    endtask

    task automatic add_item(input t_op op, input logic [63:0] now, input bit typed,
                            input t_out_item want);
        t_stim_row r;
        r             = '{cfg_idx: CFG_INTERVAL, default: '0};
        r.item.func   = op;
        r.item.now_ns = now[NOW_W-1:0];
        r.typed       = typed;
        r.want        = want;
        stim_rows.push_back(r);
    endtask

    // Receiver: drives i_ready in a randomly chosen stall style
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt[7:0] == 8'd0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= $urandom_range(0, 1);
            RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
            default:   i_ready <= (cyc_cnt[2:0] != 3'd0);
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_stats_q.size() == 0)
                report_mismatch("unexpected result", o_data.latency_ns, '0);
            else
                check_stats(o_data, expected_stats_q.pop_front());
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic [63:0] iv;
        logic [63:0] data;
        logic [63:0] base;
        logic [63:0] now;
        int          wakes;
        int          pick;
        t_in_item    noise;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_ready     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // wakeup before any start works on the reset state and finishes at once
        add_item(OP_WAKE, 64'd0, 1, make_stats(0, 1, 0, 0, 0, 1, 1));
        // wakeup after finish is ignored
        add_item(OP_WAKE, 64'd5, 1, make_stats(0, 0, 0, 0, 0, 1, 1));
        add_item(OP_START, 64'd0, 1, make_stats(0, 0, NS_PER_SEC, 0, 0, 0, 0));
        add_item(OP_WAKE, 64'd50000, 0, '0);        // early, negative latency
        add_item(OP_WAKE, 64'd200000, 0, '0);       // exactly on the deadline
        add_item(OP_WAKE, 64'd350000, 0, '0);       // late by less than one period
        add_item(OP_WAKE, 64'd123456789, 0, '0);
        add_item(OP_WAKE, MAX63, 0, '0);            // past the stop time
        add_item(OP_WAKE, 64'd7, 0, '0);
        add_item(OP_START, MAX63, 1, make_stats(0, 0, NS_PER_SEC, 0, 0, 0, 0));
        add_item(OP_WAKE, 64'd0, 0, '0);            // far before the deadline
        // zero interval, widest run length, upper bits masked off
        add_cfg(CFG_INTERVAL, 64'hFFFF_FFFF_C000_0000);
        add_cfg(CFG_RUN_LENGTH, ALL_ONES);
        add_item(OP_START, 64'd0, 1, make_stats(0, 0, NS_PER_SEC, 0, 0, 0, 0));
        // largest latency takes the sum to its ceiling
        add_item(OP_WAKE, MAX63, 1, make_stats(MAX63, 1, NS_PER_SEC, MAX63, MAX63, 1, 1));
        // widest interval, zero run length
        add_cfg(CFG_INTERVAL, {34'd0, {IV_W{1'b1}}});
        add_cfg(CFG_RUN_LENGTH, 64'd0);
        add_item(OP_START, 64'd1000, 1, make_stats(0, 0, NS_PER_SEC, 0, 0, 0, 0));
        add_item(OP_WAKE, 64'd1000, 0, '0);
        // unit interval
        add_cfg(CFG_INTERVAL, 64'hFFFF_FFFF_C000_0001);
        add_cfg(CFG_RUN_LENGTH, 64'd1000000);
        add_item(OP_START, 64'd10, 0, '0);
        add_item(OP_WAKE, 64'd11, 0, '0);
        add_item(OP_WAKE, 64'd20, 0, '0);
        add_item(OP_WAKE, 64'd15, 0, '0);
        add_item(OP_WAKE, 64'd2000000, 0, '0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                wait_idle();
                write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_data);
            end else begin
                drive_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // Random phases: new settings, a start, then mostly near-deadline wakeups
        live_items = 0;
        while (live_items < RAND_ITEMS) begin
            wait_idle();
            data = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: data[IV_W-1:0] = 1;
                1: data[IV_W-1:0] = 0;
                2: data[IV_W-1:0] = {IV_W{1'b1}};
                3: data[IV_W-1:0] = $urandom_range(1, 1000);
                4: data[IV_W-1:0] = $urandom_range(1000, 1000000);
                default: ;
            endcase
            write_reg(CFG_INTERVAL, data);
            iv = (cfg_interval == '0) ? 64'd1 : {34'd0, cfg_interval};

            data = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: data[NOW_W-1:0] = iv * $urandom_range(1, 60) + $urandom_range(0, iv);
                1: data[NOW_W-1:0] = '0;
                2: data[NOW_W-1:0] = '1;
                3: data[NOW_W-1:0] = $urandom_range(0, 1000);
                4: data[NOW_W-1:0] = iv * $urandom_range(10, 80);
                default: ;
            endcase
            write_reg(CFG_RUN_LENGTH, data);

            if ($urandom_range(0, 1))
                base = {$urandom, $urandom};
            else if ($urandom_range(0, 3) == 0)
                base = MAX63 - $urandom_range(0, 1000000);
            else
                base = {24'd0, $urandom_range(0, 255), $urandom};
            send_item(OP_START, base);

            wakes = $urandom_range(8, 80);
            for (int k = 0; k < wakes; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    send_item(OP_WAKE, cur_deadline + $urandom_range(0, iv / 8));
                end else if (pick < 72) begin
                    send_item(OP_WAKE, cur_deadline);
                end else if (pick < 84) begin
                    send_item(OP_WAKE, cur_deadline - $urandom_range(1, iv));
                end else if (pick < 94) begin
                    now = cur_deadline + iv * $urandom_range(1, 6) + $urandom_range(0, iv);
                    send_item(OP_WAKE, now);
                end else begin
                    noise = {$urandom, $urandom};
                    drive_item(noise, 1'b0, '0);
                end
                if (cur_done && $urandom_range(0, 1))
                    break;
            end
        end

        wait_idle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
